### design/ftcp_pkg.sv
// Shared types, codes and the CRC step for the framed threshold command parser.
`timescale 1ns / 1ps

package ftcp_pkg;

  localparam int unsigned DefaultChannelCount = 24;
  // Channel index width covers the full channel-count range (up to 63)
  localparam int unsigned ChIdxW = 6;
  // Frame size arithmetic: length byte plus the fixed 8 bytes of overhead
  localparam int unsigned FrameSizeW = 9;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0] MagicA       = 8'h4D;
  localparam logic [7:0] MagicB       = 8'h4B;
  localparam logic [7:0] FrameVersion = 8'h03;
  localparam logic [7:0] FrameType    = 8'h10;

  localparam logic [7:0] CmdSet   = 8'h01;
  localparam logic [7:0] CmdGet   = 8'h02;
  localparam logic [7:0] CmdSave  = 8'h03;
  localparam logic [7:0] CmdReset = 8'h04;

  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StBadLen      = 3'd1;
  localparam logic [2:0] StNoData      = 3'd2;
  localparam logic [2:0] StSaveFail    = 3'd3;
  localparam logic [2:0] StUnsupported = 3'd4;
  localparam logic [2:0] StUnknown     = 3'd5;

  localparam logic OpcByte   = 1'b0;
  localparam logic OpcLookup = 1'b1;
  localparam logic KindAck    = 1'b0;
  localparam logic KindLookup = 1'b1;

  // Register index bit of paddr (registers at 4*i)
  localparam logic CfgIdxSave = 1'b0;

  // Threshold word write from the frame receiver
  typedef struct packed {
    logic              en;
    logic [ChIdxW-1:0] ch;
    logic [31:0]       data;   // {release, press}
  } tbl_wr_t;

  // Completed, checked frame
  typedef struct packed {
    logic       done;
    logic [7:0] cmd;
    logic       len_ok;
  } frm_t;

  // Result beat payload, last field in the low bits
  typedef struct packed {
    logic [15:0] release_level;
    logic [15:0] press_level;
    logic        lookup_found;
    logic        erase_request;
    logic        save_request;
    logic [2:0]  ack_code;
    logic [7:0]  ack_command;
  } res_t;

  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

### design/framed_threshold_command_parser.sv
// Top level: stream ports, command execution, lookup path, config register.
`timescale 1ns / 1ps

// Link bytes (opcode 0) are taken when ready; a frame ending with good CRC,
// version and type loads its acknowledgement beat in that same cycle. A lookup
// (opcode 1) waits in pend_q for the registered table read, then loads the
// output register. The memory has two banks: payload words of every frame go
// into the idle bank as they arrive, and a good Set command flips the active
// bank, so no copy pass follows a frame. A new beat is taken while the output
// register holds a result only if that result leaves in the same cycle. No
// clearing pass runs after reset; lookups answer not-found until a Set.
module framed_threshold_command_parser import ftcp_pkg::*; #(
  parameter int unsigned ChannelCount = DefaultChannelCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // rx_byte [7:0], channel [15:8]
  input  logic [0:0]  s_axis_tuser_i,   // opcode [0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // ack_command [7:0], ack_code [10:8], save_request [11], erase_request [12],
  // lookup_found [13], press_level [29:14], release_level [45:30], zero [47:46]
  output logic [47:0] m_axis_tdata_o,
  output logic [0:0]  m_axis_tuser_o,   // result_kind [0]
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned Depth = 2 * ChannelCount;
  localparam int unsigned AddrW = $clog2(Depth);

  logic    save_sup_q;
  logic    tvalid_q;
  logic    kind_q;
  res_t    res_q, res_d;
  logic    pend_q, pend_found_q;
  logic    tvalid_d, kind_d;
  logic    bank_q, bank_d;
  logic    valid_q, valid_d;

  logic        accept, acc_byte, acc_lookup, ch_in_range;
  logic [7:0]  rx_byte, channel;
  tbl_wr_t     wr;
  frm_t        frm;
  logic [FrameSizeW-1:0] raddr_w, waddr_w;
  logic [31:0] rdata;

  assign rx_byte = s_axis_tdata_i[7:0];
  assign channel = s_axis_tdata_i[15:8];

  assign s_axis_tready_o = !pend_q && (!tvalid_q || m_axis_tready_i);
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign acc_byte   = accept && (s_axis_tuser_i[0] == OpcByte);
  assign acc_lookup = accept && (s_axis_tuser_i[0] == OpcLookup);
  assign ch_in_range = (channel < 8'(ChannelCount));

  ftcp_frame_rx #(
    .ChannelCount(ChannelCount)
  ) u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(acc_byte),
    .byte_i      (rx_byte),
    .wr_o        (wr),
    .frm_o       (frm)
  );

  // Bank b holds entries b*ChannelCount .. b*ChannelCount+ChannelCount-1
  assign raddr_w = FrameSizeW'(channel) + (bank_q ? FrameSizeW'(ChannelCount) : '0);
  assign waddr_w = FrameSizeW'(wr.ch) + (bank_q ? '0 : FrameSizeW'(ChannelCount));

  ftcp_table_mem #(
    .Depth(Depth),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (wr.en),
    .waddr_i(waddr_w[AddrW-1:0]),
    .wdata_i(wr.data),
    .raddr_i(raddr_w[AddrW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    res_d    = res_q;
    kind_d   = kind_q;
    tvalid_d = tvalid_q && !m_axis_tready_i;
    bank_d   = bank_q;
    valid_d  = valid_q;
    if (pend_q) begin
      tvalid_d = 1'b1;
      kind_d   = KindLookup;
      res_d    = '0;
      if (pend_found_q) begin
        res_d.lookup_found  = 1'b1;
        res_d.press_level   = rdata[15:0];
        res_d.release_level = rdata[31:16];
      end
    end else if (frm.done) begin
      tvalid_d          = 1'b1;
      kind_d            = KindAck;
      res_d             = '0;
      res_d.ack_command = frm.cmd;
      unique case (frm.cmd)
        CmdSet: begin
          if (frm.len_ok) begin
            bank_d  = !bank_q;
            valid_d = 1'b1;
            res_d.ack_code = StOk;
          end else begin
            res_d.ack_code = StBadLen;
          end
        end
        CmdSave: begin
          if (!valid_q) begin
            res_d.ack_code = StNoData;
          end else if (save_sup_q) begin
            res_d.ack_code     = StOk;
            res_d.save_request = 1'b1;
          end else begin
            res_d.ack_code = StSaveFail;
          end
        end
        CmdReset: begin
          valid_d             = 1'b0;
          res_d.ack_code      = StOk;
          res_d.erase_request = save_sup_q;
        end
        CmdGet: begin
          res_d.ack_code = StUnsupported;
        end
        default: begin
          res_d.ack_code = StUnknown;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q     <= 1'b0;
      pend_q       <= 1'b0;
      pend_found_q <= 1'b0;
      bank_q       <= 1'b0;
      valid_q      <= 1'b0;
      save_sup_q   <= 1'b1;
    end else begin
      tvalid_q     <= tvalid_d;
      pend_q       <= acc_lookup;
      pend_found_q <= acc_lookup && valid_q && ch_in_range;
      bank_q       <= bank_d;
      valid_q      <= valid_d;
      if (psel_i && penable_i && pwrite_i && paddr_i[2] == CfgIdxSave) begin
        save_sup_q <= pwdata_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    kind_q <= kind_d;
  end

  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = {2'b00, res_q};
  assign m_axis_tuser_o  = kind_q;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == CfgIdxSave) ? {31'd0, save_sup_q} : 32'd0;

`ifndef SYNTH
  // A lookup read always turns into a lookup beat in the following cycle
  a_lookup_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> (tvalid_q && kind_q == KindLookup))
    else $error("lookup read did not produce a lookup beat");

  // No new beat is taken while the table read is outstanding
  a_no_accept_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !s_axis_tready_o)
    else $error("input accepted during table read");

  // Table becomes valid only through a checked Set frame
  a_valid_by_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(frm.done && frm.cmd == CmdSet && frm.len_ok))
    else $error("thresholds became valid without a good Set frame");

  // Active bank flips only together with a valid table
  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> valid_q)
    else $error("bank flipped without a valid table");
`endif

endmodule

### design/ftcp_table_mem.sv
// Threshold table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module ftcp_table_mem import ftcp_pkg::*; #(
  parameter int unsigned Depth = 2 * DefaultChannelCount,
  parameter int unsigned AddrW = $clog2(2 * DefaultChannelCount)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [31:0]      rdata_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/ftcp_frame_rx.sv
// Frame receiver: magic resync, header capture, CRC check, payload word assembly.
`timescale 1ns / 1ps

module ftcp_frame_rx import ftcp_pkg::*; #(
  parameter int unsigned ChannelCount = DefaultChannelCount
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output tbl_wr_t    wr_o,
  output frm_t       frm_o
);

  localparam int unsigned PayloadBytes = 4 * ChannelCount;
  localparam int unsigned BufSize      = PayloadBytes + 8;
  localparam int unsigned HeldW        = $clog2(BufSize + 1);

  logic [HeldW-1:0] held_q, held_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       ver_q, typ_q, cmd_q, len_q, crc_lo_q;
  logic [23:0]      asm_q;

  logic [FrameSizeW-1:0] pos, total, off, total_new;
  logic                  in_payload, last_byte, frame_ok;
  logic [15:0]           crc_next;

  assign pos       = FrameSizeW'(held_q);
  assign total     = FrameSizeW'(len_q) + FrameSizeW'(8);
  assign total_new = FrameSizeW'(byte_i) + FrameSizeW'(8);
  assign off       = pos - FrameSizeW'(6);
  assign crc_next  = crc_upd(crc_q, byte_i);

  assign in_payload = (pos >= FrameSizeW'(6)) && (pos < total - FrameSizeW'(2));
  assign last_byte  = (pos >= FrameSizeW'(6)) && (pos + FrameSizeW'(1) == total);
  assign frame_ok   = (ver_q == FrameVersion) && (typ_q == FrameType) &&
                      ({byte_i, crc_lo_q} == crc_q);

  always_comb begin
    held_d = held_q;
    crc_d  = crc_q;
    if (byte_valid_i) begin
      if (pos == FrameSizeW'(0)) begin
        if (byte_i == MagicA) begin
          held_d = HeldW'(1);
          crc_d  = crc_upd(CrcInit, byte_i);
        end
      end else if (pos == FrameSizeW'(1)) begin
        if (byte_i == MagicB) begin
          held_d = HeldW'(2);
          crc_d  = crc_next;
        end else if (byte_i == MagicA) begin
          // lost second magic, this byte opens a new search
          held_d = HeldW'(1);
          crc_d  = crc_upd(CrcInit, byte_i);
        end else begin
          held_d = '0;
          crc_d  = CrcInit;
        end
      end else if (pos < FrameSizeW'(6)) begin
        held_d = HeldW'(pos + FrameSizeW'(1));
        crc_d  = crc_next;
        if (pos == FrameSizeW'(5) && total_new > FrameSizeW'(BufSize)) begin
          held_d = '0;
          crc_d  = CrcInit;
        end
      end else if (last_byte) begin
        held_d = '0;
        crc_d  = CrcInit;
      end else begin
        held_d = HeldW'(pos + FrameSizeW'(1));
        if (in_payload) begin
          crc_d = crc_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      crc_q  <= CrcInit;
    end else begin
      held_q <= held_d;
      crc_q  <= crc_d;
    end
  end

  // Header, CRC low byte and partial payload word
  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      if (pos == FrameSizeW'(2)) ver_q <= byte_i;
      if (pos == FrameSizeW'(3)) typ_q <= byte_i;
      if (pos == FrameSizeW'(4)) cmd_q <= byte_i;
      if (pos == FrameSizeW'(5)) len_q <= byte_i;
      if (pos >= FrameSizeW'(6) && pos == total - FrameSizeW'(2)) crc_lo_q <= byte_i;
      if (in_payload && off[1:0] != 2'd3) asm_q[8*off[1:0] +: 8] <= byte_i;
    end
  end

  assign wr_o.en   = byte_valid_i && in_payload && (off < FrameSizeW'(PayloadBytes)) &&
                     (off[1:0] == 2'd3);
  assign wr_o.ch   = off[ChIdxW+1:2];
  assign wr_o.data = {byte_i, asm_q};

  assign frm_o.done   = byte_valid_i && last_byte && frame_ok;
  assign frm_o.cmd    = cmd_q;
  assign frm_o.len_ok = (FrameSizeW'(len_q) == FrameSizeW'(PayloadBytes));

endmodule
